>>> rtl/array_list_engine_defines.svh
// Assertion macros shared by the list engine.
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ALE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ale check failed");

// Next-cycle implication, checked outside reset.
`define ALE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ale check failed");

`endif

>>> rtl/ale_pkg.sv
`default_nettype none
package ale_pkg;
    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [3:0] CMD_INS_POS = 4'd0;
    localparam logic [3:0] CMD_INS_ORD = 4'd1;
    localparam logic [3:0] CMD_DEL_POS = 4'd2;
    localparam logic [3:0] CMD_DEL_KEY = 4'd3;
    localparam logic [3:0] CMD_SEARCH  = 4'd4;
    localparam logic [3:0] CMD_READ    = 4'd5;
    localparam logic [3:0] CMD_REVERSE = 4'd6;
    localparam logic [3:0] CMD_APPEND  = 4'd7;
    localparam logic [3:0] CMD_CLEAR   = 4'd8;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BADPOS = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_NOKEY  = 3'd4;

    typedef logic signed [31:0] t_word;
    typedef logic [2:0] t_cell_op;

    localparam t_cell_op CO_HOLD    = 3'd0;
    localparam t_cell_op CO_INS     = 3'd1;
    localparam t_cell_op CO_DEL     = 3'd2;
    localparam t_cell_op CO_ORD     = 3'd3;
    localparam t_cell_op CO_TAGINIT = 3'd4;
    localparam t_cell_op CO_SWAP    = 3'd5;

    typedef struct packed {
        t_cell_op        op;
        logic            phase;
        logic [AW-1:0]   p0;
        logic [CW-1:0]   n;
        t_word           val;
    } t_cell_ctl;
endpackage
`default_nettype wire

>>> rtl/ale_in_if.sv
`default_nettype none
interface ale_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [6:0]  position;
    logic signed [31:0] item_value;

    modport source (output valid, command, position, item_value, input ready);
    modport sink (input valid, command, position, item_value, output ready);
endinterface
`default_nettype wire

>>> rtl/ale_out_if.sv
`default_nettype none
interface ale_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  found_position;
    logic signed [31:0] read_value;
    logic [6:0]  element_count;

    modport source (output valid, status, found_position, read_value, element_count,
                    input ready);
    modport sink (input valid, status, found_position, read_value, element_count,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/ale_cell.sv
`default_nettype none
module ale_cell (
    input  wire logic               i_clk,
    input  wire logic [ale_pkg::AW-1:0] i_idx,
    input  wire ale_pkg::t_cell_ctl i_ctl,
    input  wire ale_pkg::t_word     i_data_l,
    input  wire logic [ale_pkg::AW-1:0] i_tag_l,
    input  wire ale_pkg::t_word     i_data_r,
    input  wire logic [ale_pkg::AW-1:0] i_tag_r,
    input  wire logic [ale_pkg::CW-1:0] i_fpos,
    input  wire ale_pkg::t_word     i_rval,
    output ale_pkg::t_word          o_data,
    output logic [ale_pkg::AW-1:0]  o_tag,
    output logic [ale_pkg::CW-1:0]  o_fpos,
    output ale_pkg::t_word          o_rval
);
    import ale_pkg::*;

    t_word         r_data, n_data;
    logic [AW-1:0] r_tag, n_tag;
    logic [CW-1:0] r_fpos, n_fpos;
    t_word         r_rval, n_rval;
    logic          w_lt_n, w_eq_n, w_first, w_last;

    assign w_lt_n    = CW'(i_idx) < i_ctl.n;
    assign w_eq_n    = CW'(i_idx) == i_ctl.n;
    assign w_first   = i_idx == '0;
    assign w_last    = i_idx == AW'(DEPTH - 1);

    always_comb begin
        n_data = r_data;
        n_tag  = r_tag;
        case (i_ctl.op)
            CO_INS: begin
                if (i_idx == i_ctl.p0) begin
                    n_data = i_ctl.val;
                end else if (i_idx > i_ctl.p0 && (w_lt_n || w_eq_n)) begin
                    n_data = i_data_l;
                end
            end
            CO_DEL: begin
                if (i_idx >= i_ctl.p0 && CW'(i_idx) + CW'(1) < i_ctl.n) begin
                    n_data = i_data_r;
                end
            end
            CO_TAGINIT: begin
                n_tag = w_lt_n ? AW'(i_ctl.n - CW'(1) - CW'(i_idx)) : i_idx;
            end
            CO_SWAP: begin
                // Odd-even transposition: sorting by tag reverses the live entries.
                if (i_idx[0] == i_ctl.phase) begin
                    if (!w_last && i_tag_r < r_tag) begin
                        n_data = i_data_r;
                        n_tag  = i_tag_r;
                    end
                end else if (!w_first && r_tag < i_tag_l) begin
                    n_data = i_data_l;
                    n_tag  = i_tag_l;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // The search and read beats ripple one cell per cycle toward the end of the row.
    // For an ordered insert the beat carries the slot after the last entry not above
    // the new value, which is where that value goes.
    always_comb begin
        if (i_ctl.op == CO_ORD) begin
            n_fpos = (w_lt_n && !(r_data > i_ctl.val)) ? CW'(i_idx) + CW'(1) : i_fpos;
        end else if (i_fpos != '0) begin
            n_fpos = i_fpos;
        end else if (w_lt_n && r_data == i_ctl.val) begin
            n_fpos = CW'(i_idx) + CW'(1);
        end else begin
            n_fpos = '0;
        end
        n_rval = (i_idx == i_ctl.p0) ? r_data : i_rval;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tag  <= n_tag;
        r_fpos <= n_fpos;
        r_rval <= n_rval;
    end

    assign o_data = r_data;
    assign o_tag  = r_tag;
    assign o_fpos = r_fpos;
    assign o_rval = r_rval;
endmodule
`default_nettype wire

>>> rtl/array_list_engine.sv
// List engine holding up to 64 signed 32-bit entries in a row of cells, one entry per
// cell; each cell trades data with its two neighbors. Commands are taken one at a time.
// Clear, unused codes and rejected commands go from accept straight to the result;
// insert, append and delete at a position pass through the execute state first. Search
// and read ripple a beat through the whole row; delete by key scans the row and, when
// the key is found, then removes the entry. Ordered insert first ripples its slot
// through the row and then inserts. Reverse sets up tags and then runs neighbor-swap
// rounds. The next command is taken while a result still waits in the output
// register.
`default_nettype none
`include "array_list_engine_defines.svh"
module array_list_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ale_in_if.sink           i_cmd,
    ale_out_if.source        o_res,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data
);
    import ale_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SWAP = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state;
    logic [6:0]    r_cap;
    logic [CW-1:0] r_n, r_cnt;
    logic [3:0]    r_cmd;
    t_cell_op      r_op;
    logic [AW-1:0] r_p0;
    t_word         r_val;
    logic [2:0]    r_status;
    logic [CW-1:0] r_fpos;
    t_word         r_rval;
    logic          r_ov;
    logic [2:0]    r_o_status;
    logic [6:0]    r_o_fpos, r_o_cnt;
    t_word         r_o_rval;

    t_cell_ctl     w_ctl;
    t_word         w_data [DEPTH];
    logic [AW-1:0] w_tag  [DEPTH];
    logic [CW-1:0] w_fpos [DEPTH];
    t_word         w_rval [DEPTH];
    logic          w_acc, w_full, w_pos_bad_ins, w_pos_bad, w_empty, w_load;
    logic [31:0]   w_lim;

    assign i_cmd.ready = r_state == S_IDLE;
    assign w_acc = i_cmd.valid && i_cmd.ready;
    assign w_load = r_state == S_DONE && (!r_ov || o_res.ready);

    assign w_lim   = (32'(r_cap) < 32'(DEPTH)) ? 32'(r_cap) : 32'(DEPTH);
    assign w_full  = 32'(r_n) >= w_lim;
    assign w_empty = r_n == '0;
    assign w_pos_bad_ins = i_cmd.position == '0 || 32'(i_cmd.position) > 32'(r_n) + 32'd1;
    assign w_pos_bad     = i_cmd.position == '0 || 32'(i_cmd.position) > 32'(r_n);

    always_comb begin
        w_ctl.op    = CO_HOLD;
        w_ctl.phase = r_cnt[0];
        w_ctl.p0    = r_p0;
        w_ctl.n     = r_n;
        w_ctl.val   = r_val;
        if (r_state == S_EXEC) begin
            w_ctl.op = r_op;
        end else if (r_state == S_SWAP) begin
            w_ctl.op = CO_SWAP;
        end else if (r_state == S_SCAN && r_cmd == CMD_INS_ORD) begin
            w_ctl.op = CO_ORD;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ale_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (AW'(g)),
            .i_ctl   (w_ctl),
            .i_data_l(g == 0 ? t_word'(0) : w_data[(g == 0) ? 0 : g - 1]),
            .i_tag_l (g == 0 ? AW'(0) : w_tag[(g == 0) ? 0 : g - 1]),
            .i_data_r(g == DEPTH - 1 ? t_word'(0) : w_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_tag_r (g == DEPTH - 1 ? '1 : w_tag[(g == DEPTH - 1) ? g : g + 1]),
            .i_fpos  (g == 0 ? CW'(0) : w_fpos[(g == 0) ? 0 : g - 1]),
            .i_rval  (g == 0 ? t_word'(0) : w_rval[(g == 0) ? 0 : g - 1]),
            .o_data  (w_data[g]),
            .o_tag   (w_tag[g]),
            .o_fpos  (w_fpos[g]),
            .o_rval  (w_rval[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= 7'd64;
            r_n     <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_cmd    <= i_cmd.command;
                        r_val    <= i_cmd.item_value;
                        r_p0     <= AW'(i_cmd.position - 7'd1);
                        r_status <= ST_OK;
                        r_fpos   <= '0;
                        r_rval   <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_DONE;
                        case (i_cmd.command)
                            CMD_INS_POS: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else if (w_pos_bad_ins) begin
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_op    <= CO_INS;
                                    r_state <= S_EXEC;
                                end
                            end
                            CMD_INS_ORD: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_APPEND: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_op    <= CO_INS;
                                    r_p0    <= AW'(r_n);
                                    r_state <= S_EXEC;
                                end
                            end
                            CMD_DEL_POS: begin
                                if (w_empty) begin
                                    r_status <= ST_EMPTY;
                                end else if (w_pos_bad) begin
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_op    <= CO_DEL;
                                    r_state <= S_EXEC;
                                end
                            end
                            CMD_DEL_KEY, CMD_SEARCH: begin
                                if (w_empty) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_READ: begin
                                if (w_empty) begin
                                    r_status <= ST_EMPTY;
                                end else if (w_pos_bad) begin
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_REVERSE: begin
                                if (w_empty) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_op    <= CO_TAGINIT;
                                    r_state <= S_EXEC;
                                end
                            end
                            CMD_CLEAR: begin
                                r_n <= '0;
                            end
                            default: begin
                                r_status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    case (r_op)
                        CO_INS, CO_ORD: r_n <= r_n + CW'(1);
                        CO_DEL:         r_n <= r_n - CW'(1);
                        CO_TAGINIT: begin
                            r_cnt   <= '0;
                            r_state <= S_SWAP;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + CW'(1);
                    // Once r_cnt reaches DEPTH the beat has left the last cell.
                    if (r_cnt == CW'(DEPTH)) begin
                        r_state <= S_DONE;
                        if (r_cmd == CMD_INS_ORD) begin
                            r_op    <= CO_INS;
                            r_p0    <= AW'(w_fpos[DEPTH-1]);
                            r_state <= S_EXEC;
                        end else if (r_cmd == CMD_READ) begin
                            r_rval <= w_rval[DEPTH-1];
                        end else if (w_fpos[DEPTH-1] == '0) begin
                            r_status <= ST_NOKEY;
                        end else begin
                            r_fpos <= w_fpos[DEPTH-1];
                            if (r_cmd == CMD_DEL_KEY) begin
                                r_op    <= CO_DEL;
                                r_p0    <= AW'(w_fpos[DEPTH-1] - CW'(1));
                                r_state <= S_EXEC;
                            end
                        end
                    end
                end
                S_SWAP: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(DEPTH - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_o_status <= r_status;
                        r_o_fpos   <= 7'(r_fpos);
                        r_o_rval   <= r_rval;
                        r_o_cnt    <= 7'(r_n);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.status         = r_o_status;
    assign o_res.found_position = r_o_fpos;
    assign o_res.read_value     = r_o_rval;
    assign o_res.element_count  = r_o_cnt;

    `ALE_ASSERT_SAME(a_count_in_range, 1'b1, 32'(r_n) <= 32'(DEPTH))
    `ALE_ASSERT_NEXT(a_exec_one_cycle, r_state == S_EXEC, r_state != S_EXEC)
    `ALE_ASSERT_NEXT(a_busy_after_accept, w_acc, !i_cmd.ready)
endmodule
`default_nettype wire
